### src/fpe_pkg.sv
// Shared types and constants of the frustum plane extractor.
// No dependencies; the front end, back end and top module import this package.
package fpe_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int SQRT_STEPS  = 35;
    localparam int ROOT_W      = 35;
    localparam int SUM_W       = 68;
    localparam int COMP_W      = 34;
    localparam int MAG_W       = 33;

    localparam logic       FUNC_COMPUTE = 1'b1;
    localparam logic       MSEL_VIEW    = 1'b1;
    localparam logic [2:0] PLANE_FAR    = 3'd5;
    localparam logic [1:0] ROW_W_IDX    = 2'd3;
    localparam logic [1:0] LAST_COMP    = 2'd3;
    localparam logic [1:0] LAST_NORM    = 2'd2;

    typedef logic [3:0] t_addr;

    typedef struct packed {
        logic               compute;
        logic               sel_view;
        t_addr              addr;
        logic signed [31:0] value;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAC_RD,
        S_MAC_MUL,
        S_MAC_ACC,
        S_PL_RDA,
        S_PL_RDB,
        S_PL_CMP,
        S_SQ_MUL,
        S_SQ_ACC,
        S_SQRT,
        S_DIV_LD,
        S_DIV,
        S_DIV_FIN,
        S_EMIT
    } t_state;

endpackage

### src/fpe_if.sv
// Handshake channels of the frustum plane extractor: element words in,
// plane words out. No dependencies.
interface fpe_in_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic               matrix_select;
    logic [1:0]         row;
    logic [1:0]         column;
    logic signed [31:0] element_value;

    modport source (output valid, func, matrix_select, row, column, element_value,
                    input ready);
    modport sink   (input valid, func, matrix_select, row, column, element_value,
                    output ready);
endinterface

interface fpe_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         plane_index;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic signed [31:0] plane_offset;
    logic               degenerate;
    logic               last;

    modport source (output valid, plane_index, normal_x, normal_y, normal_z,
                    plane_offset, degenerate, last, input ready);
    modport sink   (input valid, plane_index, normal_x, normal_y, normal_z,
                    plane_offset, degenerate, last, output ready);
endinterface

### src/fpe_front.sv
// Front end: accepts element words, decodes them into commands and queues them.
// Depends on fpe_pkg and fpe_in_if.
module fpe_front
    import fpe_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    fpe_in_if.sink   i_in,
    input  logic     i_pop,
    output t_q_head  o_head
);
    localparam int QP_W = $clog2(QUEUE_DEPTH);

    t_cmd                    r_q [QUEUE_DEPTH];
    logic [QP_W-1:0]         r_wp;
    logic [QP_W-1:0]         r_rp;
    logic [QP_W:0]           r_count;
    logic                    w_push;
    logic                    w_pop;
    t_cmd                    w_cmd;

    assign i_in.ready = (r_count != (QP_W+1)'(QUEUE_DEPTH));
    assign w_push     = i_in.valid && i_in.ready;
    assign w_pop      = i_pop && (r_count != '0);

    always_comb begin
        w_cmd.compute  = (i_in.func == FUNC_COMPUTE);
        w_cmd.sel_view = (i_in.matrix_select == MSEL_VIEW);
        w_cmd.addr     = {i_in.row, i_in.column};
        w_cmd.value    = i_in.element_value;
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_q[r_rp];

endmodule

### src/fpe_back.sv
// Back end: matrix stores, product MAC, plane forming, bit-serial square root
// and divider, output register. Depends on fpe_pkg and fpe_out_if.
module fpe_back
    import fpe_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_q_head    i_head,
    output logic       o_pop,
    fpe_out_if.source  o_out
);
    localparam int NUM_W  = 34 + FRAC_BITS;
    localparam int STEP_W = $clog2(NUM_W + 1);

    // matrix stores
    logic signed [31:0] r_proj_mem [16];
    logic signed [31:0] r_view_mem [16];
    logic signed [31:0] r_prod_mem [16];
    logic signed [31:0] r_proj_q;
    logic signed [31:0] r_view_q;
    logic signed [31:0] r_prod_q;

    t_state r_state;
    t_state n_state;

    logic [5:0]              r_cnt;
    logic [1:0]              r_j;
    logic [2:0]              r_plane;
    logic [STEP_W-1:0]       r_step;
    logic signed [63:0]      r_mprod;
    logic signed [65:0]      r_acc;
    logic signed [31:0]      r_a;
    logic signed [COMP_W-1:0] r_comp [4];
    logic [2*MAG_W-1:0]      r_sq;
    logic [SUM_W-1:0]        r_sum;
    logic [SUM_W+1:0]        r_rad;
    logic [ROOT_W+2:0]       r_rem;
    logic [ROOT_W-1:0]       r_root;
    logic                    r_degen;
    logic [NUM_W-1:0]        r_num;
    logic [ROOT_W:0]         r_drem;
    logic signed [31:0]      r_res [4];

    logic                    r_ovalid;
    logic [2:0]              r_oplane;
    logic signed [31:0]      r_ox;
    logic signed [31:0]      r_oy;
    logic signed [31:0]      r_oz;
    logic signed [31:0]      r_od;
    logic                    r_odegen;
    logic                    r_olast;

    logic                    w_pop;
    logic                    w_emit;
    logic                    w_out_free;
    t_addr                   w_pm_raddr;
    t_addr                   w_proj_raddr;
    t_addr                   w_view_raddr;

    // arithmetic
    logic signed [65:0]      w_acc_sum;
    logic signed [65:0]      w_rnd;
    logic signed [31:0]      w_prod_sat;
    logic signed [COMP_W-1:0] w_comp_a;
    logic signed [COMP_W-1:0] w_comp_b;
    logic signed [COMP_W-1:0] w_comp_cur;
    logic [COMP_W-1:0]       w_abs;
    logic [MAG_W-1:0]        w_mag;
    logic [SUM_W-1:0]        w_sum_next;
    logic [ROOT_W+2:0]       w_rem_sh;
    logic [ROOT_W+2:0]       w_trial;
    logic [ROOT_W+2:0]       w_rem_next;
    logic [ROOT_W-1:0]       w_root_next;
    logic [ROOT_W:0]         w_drem_sh;
    logic                    w_qbit;
    logic [NUM_W-1:0]        w_num_init;
    logic signed [31:0]      w_q_sat;

    assign w_out_free   = !r_ovalid || o_out.ready;
    assign w_proj_raddr = {r_cnt[5:4], r_cnt[1:0]};
    assign w_view_raddr = {r_cnt[1:0], r_cnt[3:2]};

    // product accumulate, round to nearest (ties up), saturate
    assign w_acc_sum = r_acc + {{2{r_mprod[63]}}, r_mprod};
    assign w_rnd     = w_acc_sum + (66'sd1 <<< (FRAC_BITS - 1));
    always_comb begin
        logic signed [65:0] v_shr;
        v_shr = w_rnd >>> FRAC_BITS;
        if (v_shr > 66'sd2147483647) begin
            w_prod_sat = 32'sh7FFF_FFFF;
        end else if (v_shr < -66'sd2147483648) begin
            w_prod_sat = 32'sh8000_0000;
        end else begin
            w_prod_sat = v_shr[31:0];
        end
    end

    // plane components
    assign w_comp_a   = {{2{r_a[31]}}, r_a};
    assign w_comp_b   = {{2{r_prod_q[31]}}, r_prod_q};
    assign w_comp_cur = r_comp[r_j];
    assign w_abs      = w_comp_cur[COMP_W-1] ? -w_comp_cur : w_comp_cur;
    assign w_mag      = w_abs[MAG_W-1:0];
    assign w_sum_next = r_sum + {2'b00, r_sq};

    // one root bit per cycle
    assign w_rem_sh = {r_rem[ROOT_W:0], r_rad[SUM_W+1:SUM_W]};
    assign w_trial  = {1'b0, r_root, 2'b01};
    always_comb begin
        if (w_rem_sh >= w_trial) begin
            w_rem_next  = w_rem_sh - w_trial;
            w_root_next = {r_root[ROOT_W-2:0], 1'b1};
        end else begin
            w_rem_next  = w_rem_sh;
            w_root_next = {r_root[ROOT_W-2:0], 1'b0};
        end
    end

    // one quotient bit per cycle; the numerator shifts out as the quotient shifts in
    assign w_num_init = (NUM_W'(w_mag) << FRAC_BITS) + NUM_W'(r_root >> 1);
    assign w_drem_sh  = {r_drem[ROOT_W-1:0], r_num[NUM_W-1]};
    assign w_qbit     = (w_drem_sh >= {1'b0, r_root});

    always_comb begin
        if (!w_comp_cur[COMP_W-1]) begin
            if (r_num > NUM_W'(33'h0_7FFF_FFFF)) begin
                w_q_sat = 32'sh7FFF_FFFF;
            end else begin
                w_q_sat = r_num[31:0];
            end
        end else begin
            if (r_num > NUM_W'(33'h0_8000_0000)) begin
                w_q_sat = 32'sh8000_0000;
            end else begin
                w_q_sat = -r_num[31:0];
            end
        end
    end

    // control outputs
    always_comb begin
        w_pop      = (r_state == S_IDLE) && i_head.valid;
        w_emit     = (r_state == S_EMIT) && w_out_free;
        w_pm_raddr = (r_state == S_PL_RDA) ? {ROW_W_IDX, r_j} : {r_plane[2:1], r_j};
    end

    assign o_pop = w_pop;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_pop && i_head.cmd.compute) begin
                    n_state = S_MAC_RD;
                end
            end
            S_MAC_RD:  n_state = S_MAC_MUL;
            S_MAC_MUL: n_state = S_MAC_ACC;
            S_MAC_ACC: n_state = (r_cnt == 6'd63) ? S_PL_RDA : S_MAC_RD;
            S_PL_RDA:  n_state = S_PL_RDB;
            S_PL_RDB:  n_state = S_PL_CMP;
            S_PL_CMP:  n_state = (r_j == LAST_COMP) ? S_SQ_MUL : S_PL_RDA;
            S_SQ_MUL:  n_state = S_SQ_ACC;
            S_SQ_ACC:  n_state = (r_j == LAST_NORM) ? S_SQRT : S_SQ_MUL;
            S_SQRT: begin
                if (r_step == STEP_W'(SQRT_STEPS - 1)) begin
                    n_state = (w_root_next == '0) ? S_EMIT : S_DIV_LD;
                end
            end
            S_DIV_LD:  n_state = S_DIV;
            S_DIV: begin
                if (r_step == STEP_W'(NUM_W - 1)) begin
                    n_state = S_DIV_FIN;
                end
            end
            S_DIV_FIN: n_state = (r_j == LAST_COMP) ? S_EMIT : S_DIV_LD;
            S_EMIT: begin
                if (w_emit) begin
                    n_state = (r_plane == PLANE_FAR) ? S_IDLE : S_PL_RDA;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // stores: input matrices written on pop, product store written by the MAC; all read every cycle
    always_ff @(posedge i_clk) begin
        if (w_pop && i_head.cmd.sel_view) begin
            r_view_mem[i_head.cmd.addr] <= i_head.cmd.value;
        end
        if (w_pop && !i_head.cmd.sel_view) begin
            r_proj_mem[i_head.cmd.addr] <= i_head.cmd.value;
        end
        if ((r_state == S_MAC_ACC) && (r_cnt[1:0] == 2'd3)) begin
            r_prod_mem[r_cnt[5:2]] <= w_prod_sat;
        end
        r_proj_q <= r_proj_mem[w_proj_raddr];
        r_view_q <= r_view_mem[w_view_raddr];
        r_prod_q <= r_prod_mem[w_pm_raddr];
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_cnt <= '0;
                r_acc <= '0;
            end
            S_MAC_MUL: r_mprod <= r_proj_q * r_view_q;
            S_MAC_ACC: begin
                r_acc   <= (r_cnt[1:0] == 2'd3) ? '0 : w_acc_sum;
                r_cnt   <= r_cnt + 1'b1;
                r_plane <= '0;
                r_j     <= '0;
            end
            S_PL_RDB: r_a <= r_prod_q;
            S_PL_CMP: begin
                r_comp[r_j] <= r_plane[0] ? (w_comp_a - w_comp_b) : (w_comp_a + w_comp_b);
                r_j         <= (r_j == LAST_COMP) ? 2'd0 : r_j + 1'b1;
                r_sum       <= '0;
            end
            S_SQ_MUL: r_sq <= w_mag * w_mag;
            S_SQ_ACC: begin
                r_sum  <= w_sum_next;
                r_rad  <= {2'b00, w_sum_next};
                r_rem  <= '0;
                r_root <= '0;
                r_step <= '0;
                r_j    <= (r_j == LAST_NORM) ? 2'd0 : r_j + 1'b1;
            end
            S_SQRT: begin
                r_rad   <= {r_rad[SUM_W-1:0], 2'b00};
                r_rem   <= w_rem_next;
                r_root  <= w_root_next;
                r_step  <= r_step + 1'b1;
                r_degen <= (w_root_next == '0);
            end
            S_DIV_LD: begin
                r_num  <= w_num_init;
                r_drem <= '0;
                r_step <= '0;
            end
            S_DIV: begin
                r_drem <= w_qbit ? (w_drem_sh - {1'b0, r_root}) : w_drem_sh;
                r_num  <= {r_num[NUM_W-2:0], w_qbit};
                r_step <= r_step + 1'b1;
            end
            S_DIV_FIN: begin
                r_res[r_j] <= w_q_sat;
                r_j        <= (r_j == LAST_COMP) ? 2'd0 : r_j + 1'b1;
            end
            S_EMIT: begin
                if (w_emit) begin
                    r_plane <= r_plane + 1'b1;
                    r_j     <= '0;
                end
            end
            default: r_cnt <= r_cnt;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_oplane <= r_plane;
            r_ox     <= r_degen ? '0 : r_res[0];
            r_oy     <= r_degen ? '0 : r_res[1];
            r_oz     <= r_degen ? '0 : r_res[2];
            r_od     <= r_degen ? '0 : r_res[3];
            r_odegen <= r_degen;
            r_olast  <= (r_plane == PLANE_FAR);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out.valid        = r_ovalid;
    assign o_out.plane_index  = r_oplane;
    assign o_out.normal_x     = r_ox;
    assign o_out.normal_y     = r_oy;
    assign o_out.normal_z     = r_oz;
    assign o_out.plane_offset = r_od;
    assign o_out.degenerate   = r_odegen;
    assign o_out.last         = r_olast;

`ifndef ASSERT_OFF
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_odegen) |-> (r_ox == '0 && r_oy == '0 && r_oz == '0 && r_od == '0))
        else $error("degenerate plane carries nonzero fields");

    a_last_far: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_olast == (r_oplane == PLANE_FAR)))
        else $error("last flag out of step with plane index");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_pop)
        else $error("queue popped while a compute is running");

    a_emit_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_ovalid && !o_out.ready) |=> (r_state == S_EMIT))
        else $error("plane dropped while output stalled");
`endif

endmodule

### src/frustum_plane_extractor_unit.sv
// Frustum plane extractor: element loads pass a 2-deep command queue; a load
// retires from idle, so loads stream at one word per cycle while no compute runs.
// A compute word runs the 64 MAC steps of the product, then for each of the six planes
// forms the components, takes the square root of the normal's squared length (one bit a
// cycle) and divides the four components by it (one bit a cycle); a zero root skips this.
// Reset clears queue pointers, sequencer and output valid; matrix stores are not cleared.
module frustum_plane_extractor_unit
    import fpe_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fpe_in_if.sink     i_in,
    fpe_out_if.source  o_out
);
    t_q_head w_head;
    logic    w_pop;

    fpe_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_pop   (w_pop),
        .o_head  (w_head)
    );

    fpe_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule
